// ===== rtl/binary_max_heap_queue_assert.svh =====
// assertion macros shared by the heap queue rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMHQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMHQ_ASSERT(lbl, prop, msg)
`define BMHQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/bmhq_pkg.sv =====
// shared types, constants and the microcode table of the heap queue
// no dependencies
package bmhq_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 32;

  localparam int KEY_W       = 32;
  localparam int OCC_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int RES_W       = 2 * KEY_W + 1 + OCC_W + STATUS_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_DISP      = 5'd1;
  localparam step_t S_INS_CHK   = 5'd2;
  localparam step_t S_INS_INIT  = 5'd3;
  localparam step_t S_UP_RD     = 5'd4;
  localparam step_t S_UP_CMP    = 5'd5;
  localparam step_t S_UP_MV     = 5'd6;
  localparam step_t S_PLACE     = 5'd7;
  localparam step_t S_POP_RD    = 5'd8;
  localparam step_t S_POP_LAST  = 5'd9;
  localparam step_t S_POP_INIT  = 5'd10;
  localparam step_t S_DN_RDL    = 5'd11;
  localparam step_t S_DN_RDR    = 5'd12;
  localparam step_t S_DN_PICK   = 5'd13;
  localparam step_t S_DN_CMP    = 5'd14;
  localparam step_t S_DN_MV     = 5'd15;
  localparam step_t S_TOP_RD    = 5'd16;
  localparam step_t S_TOP_CAP   = 5'd17;
  localparam step_t S_EMIT      = 5'd18;
  localparam step_t S_EMIT_WAIT = 5'd19;
  localparam step_t S_ERR_FULL  = 5'd20;
  localparam step_t S_ERR_EMPTY = 5'd21;

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_PARENT = 3'd1,
    RD_LEFT   = 3'd2,
    RD_RIGHT  = 3'd3,
    RD_ROOT   = 3'd4,
    RD_LAST   = 3'd5
  } rd_sel_t;

  typedef enum logic [3:0] {
    A_NONE      = 4'd0,
    A_CLEAR     = 4'd1,
    A_INS_INIT  = 4'd2,
    A_UP_MV     = 4'd3,
    A_PLACE     = 4'd4,
    A_CAP_POP   = 4'd5,
    A_POP_INIT  = 4'd6,
    A_BEST_L    = 4'd7,
    A_PICK      = 4'd8,
    A_DN_MV     = 4'd9,
    A_TOP_CAP   = 4'd10,
    A_EMIT      = 4'd11,
    A_ERR_FULL  = 4'd12,
    A_ERR_EMPTY = 4'd13
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NOT_ACC     = 4'd2,
    C_IS_POP      = 4'd3,
    C_FULL        = 4'd4,
    C_EMPTY       = 4'd5,
    C_POS_ROOT    = 4'd6,
    C_NOT_GT      = 4'd7,
    C_NO_LEFT     = 4'd8,
    C_BEST_NOT_GT = 4'd9,
    C_OUT_FREE    = 4'd10
  } cond_t;

  typedef struct packed {
    rd_sel_t rd;
    act_t    act;
    cond_t   cond;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic pos_root;
    logic not_gt;
    logic no_left;
    logic best_not_gt;
  } dp_flags_t;

  // popped value sits in the low bits
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                top_valid;
    logic [KEY_W-1:0]    top_value;
    logic [KEY_W-1:0]    popped_value;
  } res_t;

  // control store: not-taken jumps fall through to the next step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    case (s)
      S_IDLE:      c = '{rd: RD_NONE,   act: A_NONE,      cond: C_NOT_ACC,     target: S_IDLE};
      S_DISP:      c = '{rd: RD_NONE,   act: A_CLEAR,     cond: C_IS_POP,      target: S_POP_RD};
      S_INS_CHK:   c = '{rd: RD_NONE,   act: A_NONE,      cond: C_FULL,        target: S_ERR_FULL};
      S_INS_INIT:  c = '{rd: RD_NONE,   act: A_INS_INIT,  cond: C_NEVER,       target: S_IDLE};
      S_UP_RD:     c = '{rd: RD_PARENT, act: A_NONE,      cond: C_POS_ROOT,    target: S_PLACE};
      S_UP_CMP:    c = '{rd: RD_NONE,   act: A_NONE,      cond: C_NOT_GT,      target: S_PLACE};
      S_UP_MV:     c = '{rd: RD_NONE,   act: A_UP_MV,     cond: C_ALWAYS,      target: S_UP_RD};
      S_PLACE:     c = '{rd: RD_NONE,   act: A_PLACE,     cond: C_ALWAYS,      target: S_TOP_RD};
      S_POP_RD:    c = '{rd: RD_ROOT,   act: A_NONE,      cond: C_EMPTY,       target: S_ERR_EMPTY};
      S_POP_LAST:  c = '{rd: RD_LAST,   act: A_CAP_POP,   cond: C_NEVER,       target: S_IDLE};
      S_POP_INIT:  c = '{rd: RD_NONE,   act: A_POP_INIT,  cond: C_NEVER,       target: S_IDLE};
      S_DN_RDL:    c = '{rd: RD_LEFT,   act: A_NONE,      cond: C_NO_LEFT,     target: S_PLACE};
      S_DN_RDR:    c = '{rd: RD_RIGHT,  act: A_BEST_L,    cond: C_NEVER,       target: S_IDLE};
      S_DN_PICK:   c = '{rd: RD_NONE,   act: A_PICK,      cond: C_NEVER,       target: S_IDLE};
      S_DN_CMP:    c = '{rd: RD_NONE,   act: A_NONE,      cond: C_BEST_NOT_GT, target: S_PLACE};
      S_DN_MV:     c = '{rd: RD_NONE,   act: A_DN_MV,     cond: C_ALWAYS,      target: S_DN_RDL};
      S_TOP_RD:    c = '{rd: RD_ROOT,   act: A_NONE,      cond: C_NEVER,       target: S_IDLE};
      S_TOP_CAP:   c = '{rd: RD_NONE,   act: A_TOP_CAP,   cond: C_NEVER,       target: S_IDLE};
      S_EMIT:      c = '{rd: RD_NONE,   act: A_EMIT,      cond: C_OUT_FREE,    target: S_IDLE};
      S_EMIT_WAIT: c = '{rd: RD_NONE,   act: A_NONE,      cond: C_ALWAYS,      target: S_EMIT};
      S_ERR_FULL:  c = '{rd: RD_NONE,   act: A_ERR_FULL,  cond: C_ALWAYS,      target: S_TOP_RD};
      S_ERR_EMPTY: c = '{rd: RD_NONE,   act: A_ERR_EMPTY, cond: C_ALWAYS,      target: S_TOP_RD};
      default:     c = '{rd: RD_NONE,   act: A_NONE,      cond: C_ALWAYS,      target: S_IDLE};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bmhq_seq.sv =====
// microcode sequencer: step counter, control store lookup and jump logic
// depends on bmhq_pkg and the assertion macro header
`include "binary_max_heap_queue_assert.svh"

module bmhq_seq
  import bmhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  dp_flags_t flags,
  output ctrl_t     ctrl,
  output logic      ready
);

  step_t upc_r, upc_nxt;
  logic  take;

  assign ctrl  = ucode(upc_r);
  assign ready = (upc_r == S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NOT_ACC:     take = !in_fire;
      C_IS_POP:      take = flags.is_pop;
      C_FULL:        take = flags.full;
      C_EMPTY:       take = flags.empty;
      C_POS_ROOT:    take = flags.pos_root;
      C_NOT_GT:      take = flags.not_gt;
      C_NO_LEFT:     take = flags.no_left;
      C_BEST_NOT_GT: take = flags.best_not_gt;
      C_OUT_FREE:    take = out_free;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? ctrl.target : step_t'(upc_r + step_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  `BMHQ_ASSERT(a_leave_idle, in_fire |=> !ready, "sequencer stayed idle after a request")

endmodule

// ===== rtl/bmhq_dp.sv =====
// heap datapath: key memory, sift registers, count and result fields
// depends on bmhq_pkg and the assertion macro header
`include "binary_max_heap_queue_assert.svh"

module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_t            ctrl,
  input  logic             in_fire,
  input  logic             in_op,
  input  logic [KEY_W-1:0] in_key,
  output dp_flags_t        flags,
  output res_t             res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);

  logic signed [KEY_BITS-1:0] mem [CAPACITY];

  logic signed [KEY_BITS-1:0] rdata_r, hold_r, best_r, key_r, popped_r, top_r;
  logic                       op_r;
  logic [CNT_W-1:0]           count_r, pos_r, bidx_r;
  logic [STATUS_W-1:0]        status_r;

  logic [CNT_W:0]             ridx;
  logic [AW-1:0]              raddr, waddr;
  logic                       rd_en, wr_en, right_ok;
  logic signed [KEY_BITS-1:0] wdata;

  function automatic logic [KEY_W-1:0] to_out(input logic signed [KEY_BITS-1:0] k);
    logic signed [63:0] w;
    w = 64'(k);
    return w[KEY_W-1:0];
  endfunction

  // heap positions are 1-based, memory addresses 0-based
  always_comb begin
    case (ctrl.rd)
      RD_PARENT: ridx = {1'b0, pos_r} >> 1;
      RD_LEFT:   ridx = {pos_r, 1'b0};
      RD_RIGHT:  ridx = {pos_r, 1'b1};
      RD_ROOT:   ridx = (CNT_W + 1)'(1);
      RD_LAST:   ridx = {1'b0, count_r};
      default:   ridx = '0;
    endcase
  end

  assign rd_en    = (ctrl.rd != RD_NONE);
  assign raddr    = AW'(ridx - (CNT_W + 1)'(1));
  assign waddr    = AW'(pos_r - CNT_W'(1));
  assign wr_en    = (ctrl.act == A_UP_MV) || (ctrl.act == A_PLACE) || (ctrl.act == A_DN_MV);
  assign right_ok = ({pos_r, 1'b1} <= {1'b0, count_r});

  always_comb begin
    case (ctrl.act)
      A_UP_MV: wdata = rdata_r;
      A_DN_MV: wdata = best_r;
      default: wdata = hold_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (ctrl.act)
        A_INS_INIT: count_r <= count_r + CNT_W'(1);
        A_POP_INIT: count_r <= count_r - CNT_W'(1);
        default:    count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      key_r <= KEY_BITS'(in_key);
    end
    case (ctrl.act)
      A_CLEAR: begin
        popped_r <= '0;
        status_r <= ST_OK;
      end
      A_INS_INIT: begin
        pos_r  <= count_r + CNT_W'(1);
        hold_r <= key_r;
      end
      A_UP_MV: pos_r <= pos_r >> 1;
      A_CAP_POP: popped_r <= rdata_r;
      A_POP_INIT: begin
        hold_r <= rdata_r;
        pos_r  <= CNT_W'(1);
      end
      A_BEST_L: begin
        best_r <= rdata_r;
        bidx_r <= CNT_W'({pos_r, 1'b0});
      end
      A_PICK: begin
        // left child wins a tie
        if (right_ok && (rdata_r > best_r)) begin
          best_r <= rdata_r;
          bidx_r <= CNT_W'({pos_r, 1'b1});
        end
      end
      A_DN_MV: pos_r <= bidx_r;
      A_TOP_CAP: top_r <= (count_r == '0) ? '0 : rdata_r;
      A_ERR_FULL: status_r <= ST_FULL;
      A_ERR_EMPTY: status_r <= ST_EMPTY;
      default: ;
    endcase
  end

  assign flags.is_pop      = (op_r == OP_POP);
  assign flags.full        = (count_r == CNT_W'(CAPACITY));
  assign flags.empty       = (count_r == '0);
  assign flags.pos_root    = (pos_r == CNT_W'(1));
  assign flags.not_gt      = !(hold_r > rdata_r);
  assign flags.no_left     = ({pos_r, 1'b0} > {1'b0, count_r});
  assign flags.best_not_gt = !(best_r > hold_r);

  assign res.popped_value = to_out(popped_r);
  assign res.top_value    = to_out(top_r);
  assign res.top_valid    = (count_r != '0);
  assign res.occupancy    = OCC_W'(count_r);
  assign res.status       = status_r;

  `BMHQ_ASSERT(a_count_range, count_r <= CNT_W'(CAPACITY), "element count above capacity")
  `BMHQ_ASSERT(a_wr_range, wr_en |-> (pos_r != '0) && (pos_r <= CNT_W'(CAPACITY)), "write outside heap")
  `BMHQ_ASSERT(a_full_hold, (ctrl.act == A_ERR_FULL) |=> (count_r == CNT_W'(CAPACITY)), "full insert changed count")

endmodule

// ===== rtl/binary_max_heap_queue.sv =====
// Binary max-heap priority queue of signed keys with a stream request and result channel.
// A request with in_tuser low inserts in_tdata; with in_tuser high it pops the maximum.
// Each request gives one result: popped key, new top, top valid, occupancy and status
// (ok, pop on empty, insert on full; rejected requests leave the heap unchanged).
// A microcoded sequencer drives a single-port key memory with registered read data, one
// access per cycle. An insert climbs level by level with a parent read, a compare and a
// move; a pop sinks the last key from the root with reads of both children, a pick, a
// compare and a move per level; every request then reads the root for the new top and
// emits its result. The sequencer then returns to its idle step, the only step that takes
// a request, so requests are taken one at a time; the result register lets the next
// request start while a result waits, and a second result held up by out_tready stalls
// the sequencer, which alternates between its emit and emit-wait steps until the result
// register frees. No clearing pass after reset.
// Depends on bmhq_pkg, bmhq_seq, bmhq_dp and the assertion macro header.
`include "binary_max_heap_queue_assert.svh"

module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,   // key
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // popped_value, top_value, top_valid,
                                             // occupancy, status, zero fill
);

  ctrl_t     ctrl;
  dp_flags_t flags;
  res_t      res;
  res_t      out_res_r;
  logic      out_valid_r;
  logic      in_fire, out_free, ready;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = ready;
  assign out_free  = !out_valid_r || out_tready;

  bmhq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .ready    (ready)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_fire (in_fire),
    .in_op   (in_tuser),
    .in_key  (in_tdata),
    .flags   (flags),
    .res     (res)
  );

  // result register parts the sequencer from the output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.act == A_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.act == A_EMIT) && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res_r};

  `BMHQ_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule
